FILE: hdl/vhi_pkg.sv
// Package with the shared sizes, widths and codes of the versioned hash index.
package vhi_pkg;

    // Table geometry.
    localparam int TABLE_SLOTS       = 1024;
    localparam int HOME_MODULUS      = 1021;
    localparam int VERSIONS_PER_SLOT = 16;

    // Field widths of the request and response words.
    localparam int KEY_W    = 64;
    localparam int VER_W    = 64;
    localparam int OFF_W    = 32;
    localparam int STATUS_W = 2;

    // Derived widths.
    localparam int SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int CNT_W   = $clog2(VERSIONS_PER_SLOT + 1);
    localparam int VADDR_W = $clog2(TABLE_SLOTS * VERSIONS_PER_SLOT);

    // The home is found by folding the key: 2**HMOD_W is congruent to FOLD_C modulo the
    // home modulus, so the bits above HMOD_W are multiplied by FOLD_C and added back in.
    // A home past the table is then reduced again by the slot count.
    localparam int MOD_MAX = (HOME_MODULUS > TABLE_SLOTS) ? HOME_MODULUS : TABLE_SLOTS;
    localparam int REM_W   = $clog2(MOD_MAX);
    localparam int HMOD_W  = $clog2(HOME_MODULUS);
    localparam int FOLD_C  = (1 << HMOD_W) - HOME_MODULUS;

    // Operation codes.
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_SEARCH = 1'b1
    } t_op;

    // Response status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_LIST_FULL  = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_NO_MATCH   = 2'd3
    } t_status;

endpackage

FILE: hdl/vhi_if.sv
// Valid/ready channel interfaces for the request and response words.
interface vhi_req_if import vhi_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             operation;
    logic [KEY_W-1:0] key;
    logic [VER_W-1:0] version;
    logic [OFF_W-1:0] offset;

    modport source (output valid, output operation, output key, output version,
                    output offset, input ready);
    modport sink   (input valid, input operation, input key, input version,
                    input offset, output ready);
endinterface

interface vhi_rsp_if import vhi_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [OFF_W-1:0]    found_offset;
    logic                last;

    modport source (output valid, output status, output found_offset, output last,
                    input ready);
    modport sink   (input valid, input status, input found_offset, input last,
                    output ready);
endinterface

FILE: hdl/versioned_hash_index.sv
// Top level of the versioned hash index: sequencer, remainder unit and table memories.
//
//  channel | dir | word                                  | meaning
//  i_req   | in  | operation, key, version, offset       | insert or search request
//  o_rsp   | out | status, found_offset, last            | one per search match, else one word
//
// After reset a clearing pass empties every one of the TABLE_SLOTS (1024) slots of the slot table.
// A request is accepted, folded in the shared fold unit for a nonzero key, probed with a read
// and a check per slot, then stored for an insert, or for a search scanned with a read and a
// check per stored version before its final word. One request is in work at a time; a full response
// register stalls the sequencer only at a cycle where it must hand over a word.
module versioned_hash_index import vhi_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    vhi_req_if.sink       i_req,
    vhi_rsp_if.source     o_rsp
);

    typedef enum logic [8:0] {
        S_CLEAR     = 9'b000000001,
        S_IDLE      = 9'b000000010,
        S_HASH      = 9'b000000100,
        S_PROBE_RD  = 9'b000001000,
        S_PROBE_CHK = 9'b000010000,
        S_INSERT    = 9'b000100000,
        S_SCAN_RD   = 9'b001000000,
        S_SCAN_CHK  = 9'b010000000,
        S_FINISH    = 9'b100000000
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] cnt;
    } t_tab_ent;

    typedef struct packed {
        logic [VER_W-1:0] version;
        logic [OFF_W-1:0] offset;
    } t_ver_ent;

    localparam logic [HMOD_W:0]   MOD_H     = (HMOD_W+1)'(HOME_MODULUS);
    localparam logic [HMOD_W-1:0] FOLD_K    = HMOD_W'(FOLD_C);
    localparam logic [REM_W:0]    SLOTS_R   = (REM_W+1)'(TABLE_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
    localparam logic [CNT_W-1:0]  VPS_C     = CNT_W'(VERSIONS_PER_SLOT);

    // Control and request registers.
    t_state             r_state, n_state;
    t_op                r_op, n_op;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [VER_W-1:0]   r_version, n_version;
    logic [OFF_W-1:0]   r_offset, n_offset;

    // Fold unit.
    logic [KEY_W-1:0]   r_sh, n_sh;
    logic [KEY_W-1:0]   fold_sum;
    logic               fold_done;
    logic [HMOD_W-1:0]  hash_rem;
    logic [REM_W-1:0]   home_w;

    // Probe and scan.
    logic [SLOT_W-1:0]  r_pos, n_pos;
    logic [SLOT_W-1:0]  r_probe_n, n_probe_n;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic               r_hit, n_hit;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_pend_v, n_pend_v;
    logic [OFF_W-1:0]   r_pend_off, n_pend_off;
    logic [SLOT_W-1:0]  probe_addr;
    logic               key_zero;
    logic               hit_match;
    logic               hit_any;
    logic               qual;

    // Response register.
    logic               r_out_v, n_out_v;
    t_status            r_out_status;
    logic [OFF_W-1:0]   r_out_off;
    logic               r_out_last;
    logic               out_free;
    logic               push;
    t_status            push_status;
    logic [OFF_W-1:0]   push_off;
    logic               push_last;

    // Memories and their ports.
    t_tab_ent           r_tab_mem [TABLE_SLOTS];
    t_ver_ent           r_ver_mem [TABLE_SLOTS * VERSIONS_PER_SLOT];
    t_tab_ent           r_tab_rd;
    t_ver_ent           r_ver_rd;
    logic               tab_we, tab_re, ver_we, ver_re;
    logic [SLOT_W-1:0]  tab_wa;
    t_tab_ent           tab_wd;
    logic [VADDR_W-1:0] ver_addr;
    logic [CNT_W-1:0]   ver_idx;

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_v;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.found_offset = r_out_off;
    assign o_rsp.last         = r_out_last;

    assign out_free   = !r_out_v || o_rsp.ready;
    assign key_zero   = (r_key == '0);
    assign probe_addr = key_zero ? '0 : ((r_pos == '0) ? SLOT_W'(1) : r_pos);
    assign hit_match  = key_zero || (r_tab_rd.key == r_key);
    assign hit_any    = hit_match || (r_tab_rd.key == '0);
    assign qual       = (r_ver_rd.version <= r_version);
    assign ver_idx    = (r_state == S_INSERT) ? r_cnt : r_idx;
    assign ver_addr   = VADDR_W'(r_slot) * VADDR_W'(VERSIONS_PER_SLOT) + VADDR_W'(ver_idx);

    // One fold step: the bits above the modulus width come back in times FOLD_C.
    // Once the value fits the modulus width, one compare and subtract leaves the remainder.
    assign fold_sum  = KEY_W'(r_sh[KEY_W-1:HMOD_W]) * KEY_W'(FOLD_K)
                     + KEY_W'(r_sh[HMOD_W-1:0]);
    assign fold_done = (r_sh[KEY_W-1:HMOD_W] == '0);
    assign hash_rem  = ({1'b0, r_sh[HMOD_W-1:0]} >= MOD_H) ?
                       HMOD_W'({1'b0, r_sh[HMOD_W-1:0]} - MOD_H) : r_sh[HMOD_W-1:0];
    assign home_w    = REM_W'(hash_rem);

    // Sequencer.
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_key      = r_key;
        n_version  = r_version;
        n_offset   = r_offset;
        n_sh       = r_sh;
        n_pos      = r_pos;
        n_probe_n  = r_probe_n;
        n_slot     = r_slot;
        n_hit      = r_hit;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_pend_v   = r_pend_v;
        n_pend_off = r_pend_off;
        push        = 1'b0;
        push_status = ST_OK;
        push_off    = '0;
        push_last   = 1'b1;
        tab_we = 1'b0;
        tab_re = 1'b0;
        ver_we = 1'b0;
        ver_re = 1'b0;
        tab_wa = r_pos;
        tab_wd = '0;

        case (r_state)
            S_CLEAR: begin
                // Empty one slot a cycle.
                tab_we = 1'b1;
                if (r_pos == LAST_SLOT) begin
                    n_pos   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op      = t_op'(i_req.operation);
                    n_key     = i_req.key;
                    n_version = i_req.version;
                    n_offset  = i_req.offset;
                    n_probe_n = '0;
                    n_pend_v  = 1'b0;
                    if (i_req.key == '0) begin
                        n_state = S_PROBE_RD;
                    end else begin
                        n_sh    = i_req.key;
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (!fold_done) begin
                    n_sh = fold_sum;
                end else begin
                    n_probe_n = '0;
                    n_state   = S_PROBE_RD;
                    if (home_w == '0) begin
                        n_pos = LAST_SLOT;
                    end else if ({1'b0, home_w} >= SLOTS_R) begin
                        // Home past the table wraps by the slot count; a wrapped zero
                        // moves to slot one.
                        n_pos = (home_w[SLOT_W-1:0] == '0) ? SLOT_W'(1) : home_w[SLOT_W-1:0];
                    end else begin
                        n_pos = SLOT_W'(home_w);
                    end
                end
            end
            S_PROBE_RD: begin
                tab_re  = 1'b1;
                n_state = S_PROBE_CHK;
            end
            S_PROBE_CHK: begin
                if (hit_any) begin
                    n_slot = probe_addr;
                    n_hit  = 1'b1;
                    n_cnt  = r_tab_rd.cnt;
                    n_idx  = '0;
                    if (r_op == OP_INSERT) begin
                        n_state = S_INSERT;
                    end else if (hit_match && (r_tab_rd.cnt != '0)) begin
                        n_state = S_SCAN_RD;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else if (r_probe_n == LAST_SLOT) begin
                    // Every slot but the reserved one visited without a free or matching one.
                    n_hit   = 1'b0;
                    n_state = (r_op == OP_INSERT) ? S_INSERT : S_FINISH;
                end else begin
                    n_probe_n = r_probe_n + 1'b1;
                    n_pos     = (r_pos == LAST_SLOT) ? '0 : r_pos + 1'b1;
                    n_state   = S_PROBE_RD;
                end
            end
            S_INSERT: begin
                // Store and answer in the same cycle once the response register frees.
                if (out_free) begin
                    push    = 1'b1;
                    n_state = S_IDLE;
                    if (key_zero && (r_version == '0)) begin
                        push_status = ST_OK;
                    end else if (!r_hit) begin
                        push_status = ST_TABLE_FULL;
                    end else if (r_cnt >= VPS_C) begin
                        push_status = ST_LIST_FULL;
                    end else begin
                        push_status = ST_OK;
                        tab_we      = 1'b1;
                        tab_wa      = r_slot;
                        tab_wd.key  = r_key;
                        tab_wd.cnt  = r_cnt + 1'b1;
                        ver_we      = 1'b1;
                    end
                end
            end
            S_SCAN_RD: begin
                ver_re  = 1'b1;
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                // A qualifying version is held back one step so the final word gets last.
                if (!(qual && r_pend_v && !out_free)) begin
                    if (qual) begin
                        if (r_pend_v) begin
                            push      = 1'b1;
                            push_off  = r_pend_off;
                            push_last = 1'b0;
                        end
                        n_pend_v   = 1'b1;
                        n_pend_off = r_ver_rd.offset;
                    end
                    if (r_idx == r_cnt - 1'b1) begin
                        n_state = S_FINISH;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    push     = 1'b1;
                    n_pend_v = 1'b0;
                    n_state  = S_IDLE;
                    if (r_pend_v) begin
                        push_off = r_pend_off;
                    end else begin
                        push_status = ST_NO_MATCH;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Response register handoff.
    always_comb begin
        if (push) begin
            n_out_v = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_v = 1'b0;
        end else begin
            n_out_v = r_out_v;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_pos    <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_version  <= n_version;
        r_offset   <= n_offset;
        r_sh       <= n_sh;
        r_probe_n  <= n_probe_n;
        r_slot     <= n_slot;
        r_hit      <= n_hit;
        r_cnt      <= n_cnt;
        r_idx      <= n_idx;
        r_pend_off <= n_pend_off;
        if (push) begin
            r_out_status <= push_status;
            r_out_off    <= push_off;
            r_out_last   <= push_last;
        end
    end

    // Slot table: key and version count per slot.
    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_tab_mem[tab_wa] <= tab_wd;
        end
        if (tab_re) begin
            r_tab_rd <= r_tab_mem[probe_addr];
        end
    end

    // Version list store: one row of entries per slot.
    always_ff @(posedge i_clk) begin
        if (ver_we) begin
            r_ver_mem[ver_addr] <= {r_version, r_offset};
        end
        if (ver_re) begin
            r_ver_rd <= r_ver_mem[ver_addr];
        end
    end

    // A slot never reports more versions than a list can hold.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE_CHK) |-> (r_tab_rd.cnt <= VPS_C))
        else $error("slot version count above list size");

    // The scan index stays below the count of the slot being scanned.
    a_scan_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN_CHK) |-> (r_idx < r_cnt))
        else $error("scan index past slot count");

    // A held-back match exists only while a search scan is in progress.
    a_pend_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (r_state == S_SCAN_RD || r_state == S_SCAN_CHK || r_state == S_FINISH))
        else $error("pending match outside of a scan");

    // The clearing pass never produces a response word.
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> !r_out_v)
        else $error("response during clearing pass");

endmodule

FILE: tb/sv/tb_versioned_hash_index.sv
// Self-checking testbench for the versioned hash index: random and directed requests, shadow table.
module tb_versioned_hash_index import vhi_pkg::*; ();

    localparam int QUIET_LIMIT = 20000;

    typedef struct {
        t_op              op;
        logic [KEY_W-1:0] key;
        logic [VER_W-1:0] version;
        logic [OFF_W-1:0] offset;
    } t_req_word;

    typedef struct {
        t_status          status;
        logic [OFF_W-1:0] offset;
        logic             last;
    } t_rsp_word;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    vhi_req_if req_if ();
    vhi_rsp_if rsp_if ();

    versioned_hash_index u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Shadow copy of the slot table.
    logic [KEY_W-1:0] tbl_key   [TABLE_SLOTS];
    int unsigned      tbl_count [TABLE_SLOTS];
    logic [VER_W-1:0] tbl_ver   [TABLE_SLOTS][VERSIONS_PER_SLOT];
    logic [OFF_W-1:0] tbl_off   [TABLE_SLOTS][VERSIONS_PER_SLOT];

    t_req_word req_backlog [$];
    t_rsp_word due_rsp [$];
    t_req_word cur_req;
    int        src_gap;
    int        snk_gap;
    int        quiet_cycles;
    int        n_errors;
    bit        idle_on;

    always #4 i_clk = ~i_clk;

    // Probe for a nonzero key: first empty or matching slot, skipping the reserved slot.
    function automatic bit find_slot(input logic [KEY_W-1:0] k, output int unsigned s);
        logic [63:0] h;
        int unsigned home;
        h = k % 64'(HOME_MODULUS);
        if (h == 64'd0) h = 64'(TABLE_SLOTS - 1);
        if (h >= 64'(TABLE_SLOTS)) begin
            h = h % 64'(TABLE_SLOTS);
            if (h == 64'd0) h = 64'd1;
        end
        home = h[31:0];
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            s = (home + i) % TABLE_SLOTS;
            if (s == 0) s = 1;
            if (tbl_key[s] == '0 || tbl_key[s] == k) return 1'b1;
        end
        s = 0;
        return 1'b0;
    endfunction

    // Update the shadow table with one accepted request and queue the words it must produce.
    function automatic void predict_responses(input t_req_word r);
        int unsigned s;
        int unsigned n;
        int unsigned hits;
        int unsigned sent;
        bit          have;
        t_rsp_word   w;
        s    = 0;
        have = 1'b1;
        if (r.key != '0) have = find_slot(r.key, s);
        if (r.op == OP_INSERT) begin
            w.status = ST_OK;
            w.offset = '0;
            w.last   = 1'b1;
            if (r.key == '0 && r.version == '0) begin
                w.status = ST_OK;
            end else if (!have) begin
                w.status = ST_TABLE_FULL;
            end else if (tbl_count[s] >= VERSIONS_PER_SLOT) begin
                w.status = ST_LIST_FULL;
            end else begin
                n = tbl_count[s];
                tbl_key[s]    = r.key;
                tbl_ver[s][n] = r.version;
                tbl_off[s][n] = r.offset;
                tbl_count[s]  = n + 1;
            end
            due_rsp.push_back(w);
        end else begin
            hits = 0;
            sent = 0;
            if (have && (r.key == '0 || tbl_key[s] == r.key)) begin
                for (int i = 0; i < tbl_count[s]; i++)
                    if (tbl_ver[s][i] <= r.version) hits++;
                for (int i = 0; i < tbl_count[s]; i++) begin
                    if (tbl_ver[s][i] <= r.version) begin
                        w.status = ST_OK;
                        w.offset = tbl_off[s][i];
                        w.last   = (sent == hits - 1);
                        due_rsp.push_back(w);
                        sent++;
                    end
                end
            end
            if (hits == 0) begin
                w.status = ST_NO_MATCH;
                w.offset = '0;
                w.last   = 1'b1;
                due_rsp.push_back(w);
            end
        end
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic queue_req(input t_op op, input logic [KEY_W-1:0] k,
                             input logic [VER_W-1:0] v, input logic [OFF_W-1:0] o);
        t_req_word r;
        r.op      = op;
        r.key     = k;
        r.version = v;
        r.offset  = o;
        req_backlog.push_back(r);
    endtask

    // Wait until every request is taken and every expected word has come back.
    task automatic wait_drained();
        while (req_backlog.size() != 0 || req_if.valid || due_rsp.size() != 0)
            @(negedge i_clk);
    endtask

    // Request driver: holds a word until it is taken, with random gaps between words while idle cycles are on.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            src_gap      <= 0;
        end else begin
            if (req_if.valid && req_if.ready) predict_responses(cur_req);
            if (!req_if.valid || req_if.ready) begin
                if (src_gap != 0) begin
                    src_gap      <= src_gap - 1;
                    req_if.valid <= 1'b0;
                end else if (req_backlog.size() != 0) begin
                    cur_req = req_backlog.pop_front();
                    req_if.operation <= cur_req.op;
                    req_if.key       <= cur_req.key;
                    req_if.version   <= cur_req.version;
                    req_if.offset    <= cur_req.offset;
                    req_if.valid     <= 1'b1;
                    if (idle_on && $urandom_range(0, 5) == 0) src_gap <= $urandom_range(1, 12);
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Response checker: compare each taken word with the oldest expectation.
    always @(posedge i_clk) begin : rsp_check
        t_rsp_word want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            snk_gap      <= 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (due_rsp.size() == 0) begin
                    $error("unexpected response word: status %0d, found_offset %0h",
                           rsp_if.status, rsp_if.found_offset);
                    n_errors++;
                end else begin
                    want = due_rsp.pop_front();
                    if (rsp_if.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                        n_errors++;
                    end
                    if (rsp_if.found_offset !== want.offset) begin
                        $error("found_offset: expected %0h, got %0h",
                               want.offset, rsp_if.found_offset);
                        n_errors++;
                    end
                    if (rsp_if.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, rsp_if.last);
                        n_errors++;
                    end
                end
            end
            if (snk_gap != 0) begin
                rsp_if.ready <= 1'b0;
                snk_gap      <= snk_gap - 1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                rsp_if.ready <= 1'b0;
                snk_gap      <= $urandom_range(0, 11);
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic [KEY_W-1:0] pool [8];
        logic [KEY_W-1:0] k;
        logic [VER_W-1:0] v;
        logic [VER_W-1:0] last_ver;
        int               sel;

        req_if.valid     = 1'b0;
        req_if.operation = 1'b0;
        req_if.key       = '0;
        req_if.version   = '0;
        req_if.offset    = '0;
        rsp_if.ready     = 1'b0;
        src_gap          = 0;
        snk_gap          = 0;
        quiet_cycles     = 0;
        n_errors         = 0;
        idle_on          = 1'b1;
        last_ver         = '0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            tbl_key[i]   = '0;
            tbl_count[i] = 0;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reserved key, field extremes, collisions and the home wrap.
        queue_req(OP_INSERT, '0, '0, '1);
        queue_req(OP_SEARCH, '0, '1, '0);
        queue_req(OP_INSERT, '0, 64'd1, 32'h0000_1234);
        queue_req(OP_INSERT, '0, '1, '1);
        queue_req(OP_SEARCH, '0, '0, '0);
        queue_req(OP_SEARCH, '0, '1, '0);
        queue_req(OP_INSERT, '1, '1, '1);
        queue_req(OP_SEARCH, '1, '1 - 64'd1, '0);
        queue_req(OP_SEARCH, '1, '1, '0);
        queue_req(OP_INSERT, 64'd5, '0, '0);
        queue_req(OP_INSERT, 64'd5 + 64'(HOME_MODULUS), 64'd10, 32'd7);
        queue_req(OP_SEARCH, 64'd5 + 64'(HOME_MODULUS), 64'd10, '0);
        queue_req(OP_SEARCH, 64'd5, '0, '0);
        queue_req(OP_SEARCH, 64'd5 + 2 * 64'(HOME_MODULUS), '1, '0);
        // Home of zero maps to the last slot; the next key wraps past the reserved slot.
        queue_req(OP_INSERT, 64'(HOME_MODULUS), 64'd3, 32'd3);
        queue_req(OP_INSERT, 2 * 64'(HOME_MODULUS), 64'd4, 32'd4);
        queue_req(OP_SEARCH, 2 * 64'(HOME_MODULUS), '1, '0);
        queue_req(OP_INSERT, 64'(HOME_MODULUS) + 64'd1, 64'd5, 32'd5);
        queue_req(OP_SEARCH, 64'(HOME_MODULUS) + 64'd1, 64'd4, '0);
        queue_req(OP_SEARCH, 64'(HOME_MODULUS) + 64'd1, 64'd5, '0);
        wait_drained();

        // Random: a small key pool with one hot key so version lists fill up.
        pool[0] = '0;
        pool[1] = rand64();
        pool[2] = pool[1] + 64'(HOME_MODULUS);
        pool[3] = pool[2] + 64'(HOME_MODULUS);
        for (int i = 4; i < 8; i++) pool[i] = rand64();
        for (int n = 0; n < 180; n++) begin
            // The last part of the run goes without idle cycles.
            if (n == 140) begin
                wait_drained();
                idle_on = 1'b0;
            end
            sel = $urandom_range(0, 99);
            if (sel < 30)      k = pool[1];
            else if (sel < 90) k = pool[$urandom_range(0, 7)];
            else               k = rand64();
            if ($urandom_range(0, 99) < 55) begin
                v = $urandom_range(0, 1) ? rand64() : 64'($urandom_range(0, 255));
                last_ver = v;
                queue_req(OP_INSERT, k, v, $urandom);
            end else begin
                case ($urandom_range(0, 4))
                    0:       v = '1;
                    1:       v = '0;
                    2:       v = last_ver;
                    3:       v = 64'($urandom_range(0, 255));
                    default: v = rand64();
                endcase
                queue_req(OP_SEARCH, k, v, $urandom);
            end
        end
        wait_drained();

        repeat (64) @(negedge i_clk);
        if (n_errors == 0 && due_rsp.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
